@@ hdl/ipi_pkg.sv @@
// ipi_pkg: shared constants, operation codes and sequencer states for the
// interrupt controller. No dependencies.
package ipi_pkg;

   localparam int NUM_LINES_DEF = 64;
   localparam int MAX_DEPTH_DEF = 15;

   localparam int OP_W     = 4;
   localparam int LINE_W   = 6;
   localparam int DEPTH_W  = 4;
   localparam int COUNT_W  = 32;
   localparam int PORT_VEC = 64;

   typedef enum logic [OP_W-1:0] {
      OP_RAISE     = 4'd0,
      OP_ENTER     = 4'd1,
      OP_EXIT      = 4'd2,
      OP_ENABLE    = 4'd3,
      OP_DISABLE   = 4'd4,
      OP_MASK      = 4'd5,
      OP_UNMASK    = 4'd6,
      OP_ACK       = 4'd7,
      OP_EOI       = 4'd8,
      OP_SETTYPE   = 4'd9,
      OP_UNMASKALL = 4'd10
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'b001,
      ST_EXEC     = 3'b010,
      ST_DISPATCH = 3'b100
   } state_type;

endpackage

@@ hdl/ipi_ffs.sv @@
// ipi_ffs: lowest-set-bit finder shared by the dispatch loop.
// Depends on ipi_pkg.
module ipi_ffs #(
   parameter int NUM_LINES = ipi_pkg::NUM_LINES_DEF
) (
   input  logic [NUM_LINES-1:0]         vec,
   output logic [$clog2(NUM_LINES)-1:0] idx
);
   import ipi_pkg::*;

   localparam int IDX_W = $clog2(NUM_LINES);

   always_comb begin
      idx = '0;
      for (int i = NUM_LINES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
   end

endmodule

@@ hdl/ipi_interrupt_controller.sv @@
// ipi_interrupt_controller: top level, operation sequencer and state words.
// Depends on ipi_pkg and ipi_ffs.
//
// A register operation's single result strobes on rsp_valid in the cycle
// in which busy falls. Enter with N pending lines strobes one vector per
// cycle, lowest line first; the dispatch loop runs through one shared
// lowest-set-bit finder, one line per cycle. Results cannot be held off:
// rsp_valid is high for one cycle per result item.
module ipi_interrupt_controller #(
   parameter int NUM_LINES = ipi_pkg::NUM_LINES_DEF,
   parameter int MAX_DEPTH = ipi_pkg::MAX_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ipi_pkg::OP_W-1:0]     req_opcode,
   input  logic [ipi_pkg::LINE_W-1:0]   req_line,
   input  logic [ipi_pkg::PORT_VEC-1:0] req_raise_lines,
   input  logic                         req_hw_cleared,
   output logic                         rsp_valid,
   output logic                         rsp_has_vector,
   output logic [ipi_pkg::LINE_W-1:0]   rsp_vector,
   output logic                         rsp_last,
   output logic [ipi_pkg::COUNT_W-1:0]  rsp_device_count,
   output logic [ipi_pkg::PORT_VEC-1:0] rsp_pending,
   output logic [ipi_pkg::DEPTH_W-1:0]  rsp_depth,
   output logic                         rsp_status,
   input  logic                         csr_wr_en,
   input  logic [ipi_pkg::LINE_W-1:0]   csr_wr_data
);
   import ipi_pkg::*;

   localparam int         IDX_W       = $clog2(NUM_LINES);
   localparam logic [7:0] MAX_DEPTH_C = 8'(MAX_DEPTH);

   state_type state_ff, state_in;

   logic [OP_W-1:0]      op_ff, op_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic [NUM_LINES-1:0] raise_ff, raise_in;
   logic                 hwc_ff, hwc_in;

   logic [LINE_W-1:0]    resched_ff, resched_in;
   logic [NUM_LINES-1:0] event_ff, event_in;
   logic [NUM_LINES-1:0] mask_ff, mask_in;
   logic [NUM_LINES-1:0] disable_ff, disable_in;
   logic [NUM_LINES-1:0] hwcl_ff, hwcl_in;
   logic [NUM_LINES-1:0] remain_ff, remain_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hv_ff, rsp_hv_in;
   logic [LINE_W-1:0]    rsp_vec_ff, rsp_vec_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [PORT_VEC-1:0]  rsp_pend_ff, rsp_pend_in;
   logic [DEPTH_W-1:0]   rsp_depth_ff, rsp_depth_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic [NUM_LINES-1:0] line_bit;
   logic [NUM_LINES-1:0] pend_cur;
   logic [IDX_W-1:0]     ffs_idx;
   logic [LINE_W-1:0]    ffs_line;
   logic                 status;
   logic                 dispatch;

   ipi_ffs #(.NUM_LINES(NUM_LINES)) u_ffs (
      .vec (remain_ff),
      .idx (ffs_idx)
   );

   assign ffs_line = LINE_W'(ffs_idx);
   assign pend_cur = event_ff & ~mask_ff;

   // lines beyond NUM_LINES decode to no bit at all
   always_comb begin
      for (int i = 0; i < NUM_LINES; i++) begin
         line_bit[i] = (line_ff == LINE_W'(i));
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      line_in       = line_ff;
      raise_in      = raise_ff;
      hwc_in        = hwc_ff;
      resched_in    = resched_ff;
      event_in      = event_ff;
      mask_in       = mask_ff;
      disable_in    = disable_ff;
      hwcl_in       = hwcl_ff;
      remain_in     = remain_ff;
      depth_in      = depth_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_hv_in     = rsp_hv_ff;
      rsp_vec_in    = rsp_vec_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_pend_in   = rsp_pend_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      status        = 1'b0;
      dispatch      = 1'b0;

      if (csr_wr_en) begin
         resched_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               line_in  = req_line;
               raise_in = req_raise_lines[NUM_LINES-1:0];
               hwc_in   = req_hw_cleared;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_RAISE: event_in = event_ff | raise_ff;
               OP_ENTER: begin
                  if ({4'd0, depth_ff} >= MAX_DEPTH_C || depth_ff == '1) begin
                     status = 1'b1;
                  end else begin
                     remain_in = pend_cur;
                     mask_in   = mask_ff | pend_cur;
                     depth_in  = depth_ff + DEPTH_W'(1);
                     dispatch  = (pend_cur != '0);
                  end
               end
               OP_EXIT: begin
                  if (depth_ff == '0) begin
                     status = 1'b1;
                  end else begin
                     depth_in = depth_ff - DEPTH_W'(1);
                     if (depth_ff == DEPTH_W'(1)) begin
                        mask_in = mask_ff & disable_ff;
                     end
                  end
               end
               OP_ENABLE: begin
                  disable_in = disable_ff & ~line_bit;
                  if (depth_ff == '0) begin
                     mask_in = mask_ff & ~line_bit;
                  end
               end
               OP_DISABLE: begin
                  disable_in = disable_ff | line_bit;
                  mask_in    = mask_ff | line_bit;
               end
               OP_MASK:   mask_in = mask_ff | line_bit;
               OP_UNMASK: mask_in = mask_ff & ~line_bit;
               OP_ACK: begin
                  if ((hwcl_ff & line_bit) == '0) begin
                     event_in = event_ff & ~line_bit;
                  end
               end
               OP_EOI: begin
                  if ((disable_ff & line_bit) == '0) begin
                     mask_in = mask_ff & ~line_bit;
                  end
               end
               OP_SETTYPE: begin
                  if (hwc_ff) begin
                     hwcl_in = hwcl_ff | line_bit;
                  end else begin
                     hwcl_in = hwcl_ff & ~line_bit;
                  end
               end
               OP_UNMASKALL: mask_in = '0;
               default: ;
            endcase

            if (dispatch) begin
               state_in = ST_DISPATCH;
            end else begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_hv_in     = 1'b0;
               rsp_vec_in    = '0;
               rsp_last_in   = 1'b1;
               rsp_count_in  = count_ff;
               rsp_pend_in   = PORT_VEC'(event_in & ~mask_in);
               rsp_depth_in  = depth_in;
               rsp_status_in = status;
            end
         end
         ST_DISPATCH: begin
            remain_in = remain_ff & ~(NUM_LINES'(1) << ffs_idx);
            if (ffs_line != resched_ff) begin
               count_in = count_ff + COUNT_W'(1);
            end
            rsp_valid_in  = 1'b1;
            rsp_hv_in     = 1'b1;
            rsp_vec_in    = ffs_line;
            rsp_last_in   = (remain_in == '0);
            rsp_count_in  = count_in;
            rsp_pend_in   = PORT_VEC'(pend_cur);
            rsp_depth_in  = depth_ff;
            rsp_status_in = 1'b0;
            if (remain_in == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         resched_ff   <= '0;
         event_ff     <= '0;
         mask_ff      <= '1;
         disable_ff   <= '0;
         hwcl_ff      <= '0;
         remain_ff    <= '0;
         depth_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resched_ff   <= resched_in;
         event_ff     <= event_in;
         mask_ff      <= mask_in;
         disable_ff   <= disable_in;
         hwcl_ff      <= hwcl_in;
         remain_ff    <= remain_in;
         depth_ff     <= depth_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      line_ff       <= line_in;
      raise_ff      <= raise_in;
      hwc_ff        <= hwc_in;
      rsp_hv_ff     <= rsp_hv_in;
      rsp_vec_ff    <= rsp_vec_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_pend_ff   <= rsp_pend_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_has_vector   = rsp_hv_ff;
   assign rsp_vector       = rsp_vec_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_device_count = rsp_count_ff;
   assign rsp_pending      = rsp_pend_ff;
   assign rsp_depth        = rsp_depth_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
